// ===== src/assert_macros.svh =====
// Assertion macros used by the sieve top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked check, disabled while reset is asserted
`define SPS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("sieve assertion failed");
// Implication form of the clocked check
`define SPS_ASSERT_IMP(lbl, ante, cons) \
	`SPS_ASSERT(lbl, (ante) |-> (cons))
`endif

// ===== src/sps_pkg.sv =====
// Shared types and constants of the segmented prime sieve
package sps_pkg;
	localparam int VALUE_BITS  = 20;
	localparam int WIN         = 64;
	localparam int WIN_IDX     = 6;
	localparam int D_BITS      = 10;
	localparam int MAX_RESULTS = 18;
	localparam int CNT_BITS    = 5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_WIDE  = 2'd3;

	// Token handed from cell to cell: current divisor, distance to next multiple, value
	typedef struct packed {
		logic                  valid;
		logic [D_BITS-1:0]     d;
		logic [D_BITS-1:0]     k;
		logic [VALUE_BITS-1:0] v;
	} token_t;

	// Index of the lowest set bit
	function automatic logic [WIN_IDX-1:0] lowest_set(input logic [WIN-1:0] vec);
		logic [WIN_IDX-1:0] idx;
		idx = '0;
		for (int i = WIN - 1; i >= 0; i--) begin
			if (vec[i]) idx = WIN_IDX'(i);
		end
		return idx;
	endfunction
endpackage

// ===== src/sps_cell.sv =====
// One window cell: holds one mark bit and passes the divisor token on
module sps_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            init,
	input  sps_pkg::token_t tok_in,
	output sps_pkg::token_t tok_out,
	output logic            mark
);
	logic mark_q;
	logic hit;
	logic valid_q;
	logic [sps_pkg::D_BITS-1:0]     d_q;
	logic [sps_pkg::D_BITS-1:0]     k_q;
	logic [sps_pkg::VALUE_BITS-1:0] v_q;

	// A multiple of d other than d itself is composite
	assign hit = tok_in.valid && (tok_in.k == '0) &&
		(tok_in.v != sps_pkg::VALUE_BITS'(tok_in.d));

	always_ff @(posedge clk) begin
		if (init) mark_q <= 1'b1;
		else if (hit) mark_q <= 1'b0;
	end

	// Hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end
	always_ff @(posedge clk) begin
		d_q <= tok_in.d;
		k_q <= (tok_in.k == '0) ? tok_in.d - 1'b1 : tok_in.k - 1'b1;
		v_q <= tok_in.v + 1'b1;
	end

	assign tok_out = '{valid: valid_q, d: d_q, k: k_q, v: v_q};
	assign mark    = mark_q;
endmodule

// ===== src/sps_mod_unit.sv =====
// Restoring remainder unit: low bound modulo divisor, one bit a cycle
module sps_mod_unit (
	input  logic                           clk,
	input  logic                           start,
	input  logic [sps_pkg::VALUE_BITS-1:0] dividend,
	input  logic [sps_pkg::D_BITS-1:0]     divisor,
	output logic [sps_pkg::D_BITS-1:0]     rem
);
	logic [sps_pkg::D_BITS-1:0]     rem_q;
	logic [sps_pkg::VALUE_BITS-1:0] sh_q;
	logic [sps_pkg::D_BITS:0]       trial;

	assign trial = {rem_q, sh_q[sps_pkg::VALUE_BITS-1]};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= dividend;
		end else begin
			sh_q <= {sh_q[sps_pkg::VALUE_BITS-2:0], 1'b0};
			if (trial >= {1'b0, divisor})
				rem_q <= sps_pkg::D_BITS'(trial - {1'b0, divisor});
			else
				rem_q <= trial[sps_pkg::D_BITS-1:0];
		end
	end

	assign rem = rem_q;
endmodule

// ===== src/segmented_prime_sieve.sv =====
// Segmented prime sieve top level: control, cell chain and result register
//
//  channel | signals                          | dir
//  in      | in_valid in_ready low_bound high_bound | request beat in
//  out     | out_valid out_ready prime_value status last | result beat out
//
// Per divisor d from 2 while d*d <= high_bound: one remainder step per bound
// bit, then a token into cell 0; the tokens then drain along the cell chain.
// A setup step samples the marks, then one result per cycle unless stalled.
// Error windows give their single result in the cycle after acceptance.
// One request at a time; in_ready is high only once all results are taken.
// Output stalls hold the result register and the sequencer.
module segmented_prime_sieve (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [19:0] low_bound,
	input  logic [19:0] high_bound,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [19:0] prime_value,
	output logic [1:0]  status,
	output logic        last
);
`include "assert_macros.svh"

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DIV   = 6'b000010,
		S_INJ   = 6'b000100,
		S_DRAIN = 6'b001000,
		S_EMIT  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	logic [sps_pkg::VALUE_BITS-1:0] lo_q, hi_q;
	logic [sps_pkg::D_BITS:0]       d_q;
	logic [sps_pkg::VALUE_BITS:0]   dsq_q;
	logic [4:0]                     step_q;
	logic [sps_pkg::WIN_IDX:0]      drain_q;
	logic [sps_pkg::WIN-1:0]        elig_q;
	logic [sps_pkg::CNT_BITS-1:0]   cnt_q;
	logic                           prep_q;
	logic                           ov_q, last_q;
	logic [sps_pkg::VALUE_BITS-1:0] pv_q;
	logic [1:0]                     st_q;

	logic                           accept, free, init;
	logic                           bad_win, ov_set;
	logic [sps_pkg::VALUE_BITS-1:0] diff;
	logic [sps_pkg::D_BITS-1:0]     rem;
	logic [sps_pkg::VALUE_BITS:0]   dsq_next;
	sps_pkg::token_t                inj_tok;
	sps_pkg::token_t                chain [sps_pkg::WIN+1];
	logic [sps_pkg::WIN-1:0]        marks, span_mask, rest;
	logic [sps_pkg::WIN_IDX-1:0]    pick;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign free     = !ov_q || out_ready;
	assign diff     = high_bound - low_bound;
	assign init     = accept;
	assign dsq_next = dsq_q + {d_q, 1'b1};

	// Empty or too wide window: single error beat
	assign bad_win = (low_bound > high_bound) ||
		(diff[sps_pkg::VALUE_BITS-1:sps_pkg::WIN_IDX] != '0);
	assign ov_set  = (state_q == S_IDLE && accept && bad_win) ||
		(state_q == S_EMIT && !prep_q && free);

	// Remainder unit for the first multiple of d in the window
	sps_mod_unit u_mod (
		.clk(clk), .start(state_q == S_INJ || accept),
		.dividend(accept ? low_bound : lo_q),
		.divisor(d_q[sps_pkg::D_BITS-1:0]), .rem(rem)
	);

	// Token into cell 0
	always_comb begin
		inj_tok.valid = (state_q == S_INJ);
		inj_tok.d     = d_q[sps_pkg::D_BITS-1:0];
		inj_tok.k     = (rem == '0) ? '0 : d_q[sps_pkg::D_BITS-1:0] - rem;
		inj_tok.v     = lo_q;
	end
	assign chain[0] = inj_tok;

	// Chain of window cells
	for (genvar i = 0; i < sps_pkg::WIN; i++) begin : g_cell
		sps_cell u_cell (
			.clk(clk), .arst_n(arst_n), .init(init),
			.tok_in(chain[i]), .tok_out(chain[i+1]), .mark(marks[i])
		);
	end

	// Cells inside the span and not holding 0 or 1
	always_comb begin
		for (int i = 0; i < sps_pkg::WIN; i++) begin
			span_mask[i] = (sps_pkg::VALUE_BITS'(i) <= hi_q - lo_q) &&
				(lo_q + sps_pkg::VALUE_BITS'(i) >= sps_pkg::VALUE_BITS'(2));
		end
	end

	assign pick = sps_pkg::lowest_set(elig_q);
	always_comb begin
		rest = elig_q;
		rest[pick] = 1'b0;
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ov_set) begin
			ov_q <= 1'b1;
		end else if (ov_q && out_ready) begin
			ov_q <= 1'b0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prep_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (bad_win) begin
							state_q <= S_DONE;
						end else if (high_bound < 20'd4) begin
							state_q <= S_DRAIN;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (step_q == 5'(sps_pkg::VALUE_BITS - 1)) state_q <= S_INJ;
				end
				S_INJ: begin
					if (dsq_next > {1'b0, hi_q}) state_q <= S_DRAIN;
					else state_q <= S_DIV;
				end
				S_DRAIN: begin
					if (drain_q == (sps_pkg::WIN_IDX+1)'(sps_pkg::WIN)) begin
						state_q <= S_EMIT;
						prep_q <= 1'b1;
					end
				end
				S_EMIT: begin
					if (prep_q) begin
						prep_q <= 1'b0;
					end else if (free) begin
						if (elig_q == '0) begin
							state_q <= S_DONE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
							if (rest == '0 ||
								cnt_q == sps_pkg::CNT_BITS'(sps_pkg::MAX_RESULTS - 1))
								state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q   <= low_bound;
			hi_q   <= high_bound;
			d_q    <= (sps_pkg::D_BITS+1)'(2);
			dsq_q  <= (sps_pkg::VALUE_BITS+1)'(4);
			step_q <= '0;
			drain_q <= '0;
			pv_q   <= '0;
			last_q <= 1'b1;
			st_q   <= (low_bound > high_bound) ? sps_pkg::ST_EMPTY : sps_pkg::ST_WIDE;
		end
		if (state_q == S_DIV) step_q <= step_q + 1'b1;
		if (state_q == S_INJ) begin
			step_q <= '0;
			d_q    <= d_q + 1'b1;
			dsq_q  <= dsq_next;
		end
		if (state_q == S_DRAIN) drain_q <= drain_q + 1'b1;
		if (state_q == S_EMIT) begin
			if (prep_q) begin
				elig_q <= marks & span_mask;
			end else if (free) begin
				if (elig_q == '0) begin
					pv_q   <= '0;
					st_q   <= sps_pkg::ST_NONE;
					last_q <= 1'b1;
				end else begin
					pv_q   <= lo_q + sps_pkg::VALUE_BITS'(pick);
					st_q   <= sps_pkg::ST_OK;
					last_q <= (rest == '0) ||
						(cnt_q == sps_pkg::CNT_BITS'(sps_pkg::MAX_RESULTS - 1));
					elig_q <= rest;
				end
			end
		end
	end

	assign out_valid   = ov_q;
	assign prime_value = pv_q;
	assign status      = st_q;
	assign last        = last_q;

	`SPS_ASSERT_IMP(a_idle_no_out, state_q == S_IDLE, !ov_q)
	`SPS_ASSERT(a_cnt_bound, cnt_q <= sps_pkg::CNT_BITS'(sps_pkg::MAX_RESULTS))
	`SPS_ASSERT_IMP(a_prime_ge2, ov_q && st_q == sps_pkg::ST_OK, pv_q >= 20'd2)
	`SPS_ASSERT_IMP(a_div_bound, state_q == S_DIV, dsq_q <= {1'b0, hi_q})
endmodule
